// ----- rtl/lfu_pkg.sv -----
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types, constants and helpers of the LFU cache table.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int unsigned MAX_ENTRIES_DFLT = 16;
    localparam int unsigned DATA_W           = 32;
    localparam int unsigned CAP_W            = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // One table entry as held in the entry memory
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] stamp;
    } entry_t;

    // Scan unit control
    typedef struct packed {
        logic clear;
        logic sample;
    } scan_ctl_t;

    // Scan unit status
    typedef struct packed {
        logic found;
        logic free_ok;
        logic vic_ok;
    } scan_sts_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

    // Saturating increment
    function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] x);
        return (x == '1) ? x : x + DATA_W'(1);
    endfunction

endpackage

// ----- rtl/lfu_mem.sv -----
// ----------------------------------------------------------------------------
// lfu_mem
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lfu_mem #(
    parameter int unsigned DEPTH = lfu_pkg::MAX_ENTRIES_DFLT,
    parameter int unsigned AW    = 4
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  lfu_pkg::entry_t wdata,
    input  logic [AW-1:0]   raddr,
    output lfu_pkg::entry_t rdata
);
    import lfu_pkg::*;

    entry_t mem [0:DEPTH-1];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/lfu_scan.sv -----
// ----------------------------------------------------------------------------
// lfu_scan
// Takes the entries one per cycle while sample is set: key match, first free slot, occupancy
// and the LFU victim (least count, then oldest stamp, then lowest index).
// ----------------------------------------------------------------------------
module lfu_scan #(
    parameter int unsigned IW          = 4,
    parameter int unsigned CNT_W       = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lfu_pkg::scan_ctl_t         ctl,
    input  logic [IW-1:0]              idx,
    input  lfu_pkg::entry_t            entry,
    input  logic [lfu_pkg::DATA_W-1:0] key,
    output lfu_pkg::scan_sts_t         sts,
    output logic [IW-1:0]              found_idx,
    output logic [lfu_pkg::DATA_W-1:0] found_value,
    output logic [lfu_pkg::DATA_W-1:0] found_count,
    output logic [IW-1:0]              free_idx,
    output logic [IW-1:0]              vic_idx,
    output logic [CNT_W-1:0]           used
);
    import lfu_pkg::*;

    scan_sts_t         sts_reg;
    logic [IW-1:0]     found_idx_reg;
    logic [DATA_W-1:0] found_value_reg;
    logic [DATA_W-1:0] found_count_reg;
    logic [IW-1:0]     free_idx_reg;
    logic [IW-1:0]     vic_idx_reg;
    logic [DATA_W-1:0] vic_count_reg;
    logic [DATA_W-1:0] vic_stamp_reg;
    logic [CNT_W-1:0]  used_reg;
    logic              better;

    // strictly better victim; equal keeps the lower index
    always_comb
    begin
        better = !sts_reg.vic_ok
              || (entry.count < vic_count_reg)
              || ((entry.count == vic_count_reg) && (entry.stamp < vic_stamp_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sts_reg         <= '0;
            used_reg        <= '0;
            found_idx_reg   <= '0;
            found_value_reg <= '0;
            found_count_reg <= '0;
            free_idx_reg    <= '0;
            vic_idx_reg     <= '0;
            vic_count_reg   <= '0;
            vic_stamp_reg   <= '0;
        end
        else if (ctl.clear)
        begin
            sts_reg  <= '0;
            used_reg <= '0;
        end
        else if (ctl.sample)
        begin
            if (!entry.valid)
            begin
                if (!sts_reg.free_ok)
                begin
                    sts_reg.free_ok <= 1'b1;
                    free_idx_reg    <= idx;
                end
            end
            else
            begin
                used_reg <= used_reg + CNT_W'(1);
                if (!sts_reg.found && (entry.key == key))
                begin
                    sts_reg.found   <= 1'b1;
                    found_idx_reg   <= idx;
                    found_value_reg <= entry.value;
                    found_count_reg <= entry.count;
                end
                if (better)
                begin
                    sts_reg.vic_ok <= 1'b1;
                    vic_idx_reg    <= idx;
                    vic_count_reg  <= entry.count;
                    vic_stamp_reg  <= entry.stamp;
                end
            end
        end
    end

    assign sts         = sts_reg;
    assign found_idx   = found_idx_reg;
    assign found_value = found_value_reg;
    assign found_count = found_count_reg;
    assign free_idx    = free_idx_reg;
    assign vic_idx     = vic_idx_reg;
    assign used        = used_reg;

endmodule

// ----- rtl/lfu_cache_table.sv -----
// ----------------------------------------------------------------------------
// lfu_cache_table
// Fully associative key/value cache with LFU replacement, LRU tie-break.
// ----------------------------------------------------------------------------
// Sequence: from start the entry memory is read through its single read port,
//   one entry per cycle, then the write-back state writes the entry and done
//   is registered; busy drops with done, so a new start is taken that same cycle.
// A new command is not taken while a transaction is in flight: busy stays high
//   from the accepted start until done.
// Reset: a clearing pass invalidates every entry with busy held high; config
//   writes are taken throughout.
// Results cannot be stalled: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module lfu_cache_table #(
    parameter int unsigned MAX_ENTRIES = lfu_pkg::MAX_ENTRIES_DFLT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // command channel
    input  logic                       start,
    output logic                       busy,
    input  logic                       operation,
    input  logic [lfu_pkg::DATA_W-1:0] key,
    input  logic [lfu_pkg::DATA_W-1:0] value,
    // configuration channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0]  cfg_data,
    // result
    output logic                       done,
    output logic                       hit,
    output logic [lfu_pkg::DATA_W-1:0] read_value
);
    import lfu_pkg::*;

    localparam int unsigned IW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

    // ---------------------------------------------------------------- state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;   // clear/scan address counter
    logic              smp_vld_reg;               // read data valid this cycle
    logic [IW-1:0]     smp_idx_reg;               // index of that read data
    logic [CAP_W-1:0]  cap_reg;
    logic [DATA_W-1:0] tick_reg;
    logic              op_reg;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] val_reg;
    logic              done_reg;
    logic              hit_reg;
    logic [DATA_W-1:0] rv_reg;

    logic              accept;

    // memory side
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    entry_t            mem_wdata;
    entry_t            mem_rdata;

    // scan side
    scan_ctl_t         scan_ctl;
    scan_sts_t         scan_sts;
    logic [IW-1:0]     found_idx;
    logic [DATA_W-1:0] found_value;
    logic [DATA_W-1:0] found_count;
    logic [IW-1:0]     free_idx;
    logic [IW-1:0]     vic_idx;
    logic [CNT_W-1:0]  used;

    // result of the write-back cycle
    logic              res_hit;
    logic [DATA_W-1:0] res_value;
    logic              at_cap;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------- units
    lfu_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (IW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_idx_reg[IW-1:0]),
        .rdata (mem_rdata)
    );

    lfu_scan #(
        .IW          (IW),
        .CNT_W       (CNT_W)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (scan_ctl),
        .idx         (smp_idx_reg),
        .entry       (mem_rdata),
        .key         (key_reg),
        .sts         (scan_sts),
        .found_idx   (found_idx),
        .found_value (found_value),
        .found_count (found_count),
        .free_idx    (free_idx),
        .vic_idx     (vic_idx),
        .used        (used)
    );

    // ---------------------------------------------------------- next state
    always_comb
    begin
        state_next  = state_reg;
        rd_idx_next = rd_idx_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (rd_idx_reg == CNT_W'(MAX_ENTRIES - 1))
                begin
                    state_next  = ST_IDLE;
                    rd_idx_next = '0;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
            end
            ST_IDLE:
            begin
                rd_idx_next = '0;
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // last entry's data is sampled in the cycle the counter hits the end
                if (rd_idx_reg == CNT_W'(MAX_ENTRIES))
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
            end
            ST_WRITE:
            begin
                state_next  = ST_IDLE;
                rd_idx_next = '0;
            end
            default:
            begin
                state_next  = ST_IDLE;
                rd_idx_next = '0;
            end
        endcase
    end

    // -------------------------------------------------------------- outputs
    // Write-back is the only memory write of a transaction and happens after
    // the scan has finished, so reads never overlap a pending write: the
    // sequencer itself is the interlock.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = found_idx;
        mem_wdata = '0;
        scan_ctl  = '0;
        res_hit   = 1'b0;
        res_value = '0;
        // with capacity above MAX_ENTRIES this never holds, which matches clamping
        at_cap    = (DATA_W'(used) >= DATA_W'(cap_reg));
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = rd_idx_reg[IW-1:0];
            end
            ST_IDLE:
            begin
                scan_ctl.clear = 1'b1;
            end
            ST_SCAN:
            begin
                scan_ctl.sample = smp_vld_reg;
            end
            ST_WRITE:
            begin
                mem_wdata.valid = 1'b1;
                mem_wdata.key   = key_reg;
                mem_wdata.stamp = tick_reg;
                if (scan_sts.found)
                begin
                    // hit: bump count, restamp, put replaces the value
                    res_hit         = 1'b1;
                    res_value       = (op_reg == OP_GET) ? found_value : '0;
                    mem_we          = 1'b1;
                    mem_waddr       = found_idx;
                    mem_wdata.value = (op_reg == OP_PUT) ? val_reg : found_value;
                    mem_wdata.count = sat_inc(found_count);
                end
                else if ((op_reg == OP_PUT) && (cap_reg != '0))
                begin
                    // insert: evict when at capacity, else lowest free slot, else the victim
                    mem_wdata.value = val_reg;
                    mem_wdata.count = DATA_W'(1);
                    if (at_cap && scan_sts.vic_ok)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = vic_idx;
                    end
                    else if (scan_sts.free_ok)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = free_idx;
                    end
                    else if (scan_sts.vic_ok)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = vic_idx;
                    end
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            rd_idx_reg  <= '0;
            smp_vld_reg <= 1'b0;
            cap_reg     <= CAP_RESET;
            tick_reg    <= DATA_W'(1);
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_idx_reg  <= rd_idx_next;
            smp_vld_reg <= (state_reg == ST_SCAN) && (rd_idx_reg < CNT_W'(MAX_ENTRIES));
            done_reg    <= (state_reg == ST_WRITE);
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            if (accept)
            begin
                tick_reg <= sat_inc(tick_reg);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        smp_idx_reg <= rd_idx_reg[IW-1:0];
        if (accept)
        begin
            op_reg  <= operation;
            key_reg <= key;
            val_reg <= value;
        end
        if (state_reg == ST_WRITE)
        begin
            hit_reg <= res_hit;
            rv_reg  <= res_value;
        end
    end

    assign done       = done_reg;
    assign hit        = hit_reg;
    assign read_value = rv_reg;

endmodule

// ----- rtl/lfu_checker.sv -----
// ----------------------------------------------------------------------------
// lfu_checker
// Port-level checks of the LFU cache table, bound to the top level.
// ----------------------------------------------------------------------------
module lfu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        hit,
    input logic [31:0] read_value
);

    // a result ends the transaction: never shown while still busy
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // an accepted command makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after accepted command");

    // a result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done longer than one cycle");

    // a miss never returns data
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (read_value == 32'd0))
        else $error("miss with non-zero read_value");

endmodule

bind lfu_cache_table lfu_checker u_lfu_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .hit        (hit),
    .read_value (read_value)
);

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lfu_cache_table. A scoreboard class mirrors the
// table (LFU replacement, oldest-stamp tie-break, capacity register) and
// queues the expected outcome of every accepted command. Each done strobe is
// checked against the oldest outcome still queued. Stimulus is a directed
// opening, then phases of random traffic over a skewed pool of hot keys
// mixed with random keys, each phase under its own capacity setting.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import lfu_pkg::*;

    localparam int unsigned SLOTS     = MAX_ENTRIES_DFLT;
    localparam int unsigned HOT_KEYS  = 24;   // a little over the table size
    localparam int unsigned PHASES    = 10;
    localparam int unsigned PHASE_LEN = 60;

    // ------------------------------------------------------------------------
    // Scoreboard: a behavioural copy of the table and a queue of outcomes
    // ------------------------------------------------------------------------
    class lfu_scoreboard;

        typedef struct {
            logic              op;
            logic [DATA_W-1:0] key;
            logic              hit;
            logic [DATA_W-1:0] read_value;
        } outcome_t;

        entry_t            slots [SLOTS];
        logic [DATA_W-1:0] tick;
        logic [CAP_W-1:0]  capacity;
        outcome_t          outcomes [$];
        int unsigned       errors;

        function new();
            foreach (slots[i])
                slots[i] = '0;
            tick     = DATA_W'(1);
            capacity = CAP_RESET;
            errors   = 0;
        endfunction

        function void set_capacity(input logic [CAP_W-1:0] c);
            capacity = c;
        endfunction

        // One accepted command: update the mirror and queue what done must show
        function void note_command(input logic op, input logic [DATA_W-1:0] k,
                                   input logic [DATA_W-1:0] v);
            int          found     = -1;
            int          free_slot = -1;
            int          victim    = -1;
            int          slot      = -1;
            int unsigned used      = 0;
            int unsigned cap;
            outcome_t    res;

            cap = (capacity > SLOTS) ? SLOTS : capacity;
            if (tick != '1)
                tick = tick + DATA_W'(1);

            // one pass: key match, first free slot, least count / oldest stamp
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!slots[i].valid)
                begin
                    if (free_slot < 0)
                        free_slot = i;
                    continue;
                end
                used++;
                if (found < 0 && slots[i].key == k)
                    found = i;
                if (victim < 0 || slots[i].count < slots[victim].count ||
                    (slots[i].count == slots[victim].count &&
                     slots[i].stamp < slots[victim].stamp))
                    victim = i;
            end

            res.op         = op;
            res.key        = k;
            res.hit        = (found >= 0);
            res.read_value = '0;

            if (found >= 0)
            begin
                if (slots[found].count != '1)
                    slots[found].count = slots[found].count + DATA_W'(1);
                slots[found].stamp = tick;
                if (op == OP_GET)
                    res.read_value = slots[found].value;
                else
                    slots[found].value = v;
            end
            else if (op == OP_PUT && cap != 0)
            begin
                // full (or over-full after a capacity cut): reuse the victim
                if (used >= cap && victim >= 0)
                    slot = victim;
                else if (free_slot >= 0)
                    slot = free_slot;
                else
                    slot = victim;
                if (slot >= 0)
                begin
                    slots[slot].valid = 1'b1;
                    slots[slot].key   = k;
                    slots[slot].value = v;
                    slots[slot].count = DATA_W'(1);
                    slots[slot].stamp = tick;
                end
            end

            outcomes.push_back(res);
        endfunction

        task report(input string what);
            $display("%0t ns ERROR %s", $time, what);
            errors++;
        endtask

        task check_result(input logic h, input logic [DATA_W-1:0] rv);
            outcome_t want;
            if (outcomes.size() == 0)
            begin
                report($sformatf("result with nothing outstanding: hit %b data %h", h, rv));
            end
            else
            begin
                want = outcomes.pop_front();
                if (h !== want.hit)
                    report($sformatf("op %b key %h: hit %b, expected %b",
                                     want.op, want.key, h, want.hit));
                if (rv !== want.read_value)
                    report($sformatf("op %b key %h: read_value %h, expected %h",
                                     want.op, want.key, rv, want.read_value));
            end
        endtask

    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block under test
    // ------------------------------------------------------------------------
    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              start      = 1'b0;
    logic              operation  = OP_GET;
    logic [DATA_W-1:0] key        = '0;
    logic [DATA_W-1:0] value      = '0;
    logic              cfg_valid  = 1'b0;
    logic [CAP_W-1:0]  cfg_data   = '0;
    logic              busy;
    logic              cfg_ready;
    logic              done;
    logic              hit;
    logic [DATA_W-1:0] read_value;

    lfu_scoreboard     sb = new();
    logic [DATA_W-1:0] hot_keys [HOT_KEYS];

    always
    begin
        #5;
        clk = 1'b1;
        #5;
        clk = 1'b0;
    end

    lfu_cache_table dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .key        (key),
        .value      (value),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .done       (done),
        .hit        (hit),
        .read_value (read_value)
    );

    // Results cannot be held off: every done strobe is checked at its edge.
    // Values read straight after the edge are the pre-edge ones.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_result(hit, read_value);
    end

    // ------------------------------------------------------------------------
    // Driving tasks (all called just after a rising edge)
    // ------------------------------------------------------------------------

    // Present one command and hold it until the block takes it. start is left
    // high so that a back-to-back transaction needs no second assignment.
    task automatic issue(input logic op, input logic [DATA_W-1:0] k,
                         input logic [DATA_W-1:0] v);
        start     <= 1'b1;
        operation <= op;
        key       <= k;
        value     <= v;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_command(op, k, v);
    endtask

    // Stop sending until every outstanding result has come back.
    // Always lets at least one edge pass, so start is never re-raised
    // in the step that lowers it.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.outcomes.size() != 0);
    endtask

    // Capacity is only changed with the table idle.
    task automatic write_capacity(input logic [CAP_W-1:0] c);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        sb.set_capacity(c);
    endtask

    // Skewed pick: low indices come up far more often, so some keys build
    // large use counts while the rest churn through eviction
    function automatic logic [DATA_W-1:0] pick_hot_key();
        return hot_keys[$urandom_range(0, $urandom_range(0, HOT_KEYS - 1))];
    endfunction

    // One phase of random traffic. Mostly hot keys and put/read-back pairs,
    // with some noise on keys from the whole range.
    task automatic random_phase(input int unsigned n, input bit quiet);
        int unsigned done_items;
        int unsigned sel;
        logic [DATA_W-1:0] k;
        done_items = 0;
        while (done_items < n)
        begin
            // idle bursts with start low, unless the phase is quiet
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 8))
                    @(posedge clk);
            end
            sel = $urandom_range(0, 99);
            if (sel < 15)
            begin
                issue($urandom_range(0, 1) ? OP_PUT : OP_GET, $urandom, $urandom);
                done_items++;
            end
            else if (sel < 35)
            begin
                k = pick_hot_key();
                issue(OP_PUT, k, $urandom);
                issue(OP_GET, k, $urandom);
                done_items += 2;
            end
            else
            begin
                issue($urandom_range(0, 1) ? OP_PUT : OP_GET, pick_hot_key(), $urandom);
                done_items++;
            end
            // now and then let the pipe empty completely mid-phase
            if (!quiet && $urandom_range(0, 59) == 0)
                drain_results();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [CAP_W-1:0] phase_caps [PHASES];

        // extremes first, including values above the table size
        phase_caps = '{CAP_W'(31), CAP_W'(0), CAP_W'(1), CAP_W'(16), CAP_W'(2),
                       CAP_W'(17), CAP_W'(8), CAP_W'(3), CAP_W'(15), CAP_W'(5)};
        foreach (hot_keys[i])
            hot_keys[i] = $urandom;
        hot_keys[0] = '0;
        hot_keys[1] = '1;

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        // --- directed opening, reset capacity; the clearing pass holds busy ---
        issue(OP_GET, '0, '1);                            // miss on an empty table
        issue(OP_PUT, '0, '0);                            // insert
        issue(OP_GET, '0, '1);                            // hit, value zero
        issue(OP_PUT, '1, '1);                            // insert, all ones
        issue(OP_GET, '1, '0);                            // hit, all ones
        issue(OP_PUT, '1, 32'h5A5A_A5A5);                 // put hit replaces
        issue(OP_GET, '1, '0);
        issue(OP_GET, 32'h1234_5678, '1);                 // miss, value ignored

        // capacity zero: put hits still update, put misses store nothing
        write_capacity(CAP_W'(0));
        issue(OP_PUT, '0, 32'h0000_0007);
        issue(OP_GET, '0, '0);
        issue(OP_PUT, 32'hDEAD_BEEF, 32'hFFFF_0000);
        issue(OP_GET, 32'hDEAD_BEEF, '0);

        // capacity cut below the occupancy: each new key evicts the LFU entry
        write_capacity(CAP_W'(1));
        issue(OP_PUT, 32'hA5A5_A5A5, 32'h0F0F_0F0F);
        issue(OP_GET, '0, '0);
        issue(OP_GET, 32'hA5A5_A5A5, '0);
        issue(OP_PUT, 32'h5A5A_5A5A, 32'hF0F0_F0F0);
        issue(OP_GET, 32'hA5A5_A5A5, '0);
        issue(OP_GET, 32'h5A5A_5A5A, '0);
        issue(OP_GET, '1, '0);

        // --- random phases, one capacity each; the last one runs flat out ---
        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(phase_caps[p]);
            repeat (4)
                hot_keys[$urandom_range(2, HOT_KEYS - 1)] = $urandom;
            random_phase(PHASE_LEN, (p == PHASES - 1) || ($urandom_range(0, 3) == 0));
        end

        // wait for the tail, then keep watching for any stray strobe
        drain_results();
        repeat (2 * (SLOTS + 3))
            @(posedge clk);

        if (sb.errors == 0)
            $display("lfu_cache_table: match");
        else
            $display("lfu_cache_table: mismatch");
        $finish;
    end

    // Watchdog, well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("lfu_cache_table: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/lfu_pkg.sv
rtl/lfu_mem.sv
rtl/lfu_scan.sv
rtl/lfu_cache_table.sv
rtl/lfu_checker.sv
tb/sv/testbench.sv
